// ----- hdl/coalescing_event_queue_defines.svh -----
// Assertion macros for the coalescing event queue
`ifndef COALESCING_EVENT_QUEUE_DEFINES_SVH
`define COALESCING_EVENT_QUEUE_DEFINES_SVH
// clocked property with asynchronous reset qualifier
`define CEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// implication from a trigger to a consequence
`define CEQ_ASSERT_IMP(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) else $error(msg);
`endif

// ----- hdl/ceq_pkg.sv -----
// Types and constants shared by the coalescing event queue
package ceq_pkg;
	typedef struct packed {
		logic [15:0] len;
		logic [31:0] gen;
		logic [31:0] seq;
		logic [63:0] rev;
		logic [2:0]  kind;
		logic [31:0] ctl;
	} entry_t;

	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_COAL  = 2'd1;
	localparam logic [1:0] OP_EVICT = 2'd2;
	localparam logic [1:0] OP_DRAIN = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  kind;
		logic [31:0] ctl;
	} cell_cmd_t;

	localparam logic [2:0] KIND_FOCUS    = 3'd0;
	localparam logic [2:0] KIND_CAPTURE  = 3'd2;
	localparam logic [2:0] KIND_DIAG     = 3'd3;
	localparam logic [2:0] KIND_OVERFLOW = 3'd4;
	localparam logic [2:0] KIND_COMMAND  = 3'd5;

	localparam logic [2:0] ST_PUSHED   = 3'd0;
	localparam logic [2:0] ST_REJECTED = 3'd1;
	localparam logic [2:0] ST_UNKNOWN  = 3'd2;
	localparam logic [2:0] ST_DRAINED  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic [4:0] CAP_RESET = 5'd16;
endpackage

// ----- hdl/coalescing_event_queue.sv -----
// Coalescing event queue: top level with control sequencer and slot chain
// A push removes the matching older entry on the accept edge; the push state then evicts if
// full, appends the event and delivers the status. A drain delivers its transactions
// (marker first, then entries oldest first) after the accept; the slot chain shifts by one
// per delivered entry. Each of these steps waits while the output register still holds a
// transaction that the receiver has not taken, and input is refused until the current push
// or drain is complete. Configuration writes take effect at once and must only happen while
// the queue is idle.
`include "coalescing_event_queue_defines.svh"
module coalescing_event_queue #(
	parameter int MAX_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ctl_id[31:0] event_kind[34:32] revision[98:35] edit_gen[130:99]
	// payload_length[146:131] zero[151:147]
	input  logic [151:0] s_tdata,
	// mode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_ctl_id[31:0] out_kind[34:32] out_revision[98:35] out_sequence[130:99]
	// out_edit_gen[162:131] payload_offset[182:163] out_payload_length[198:183]
	// pending_count[203:199] overflow_active[204] zero[207:205]
	output logic [207:0] m_tdata,
	// status
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);
	localparam int CONTENT = MAX_SLOTS - 1;
	localparam int CW = $clog2(MAX_SLOTS);
	localparam int CAPW = (CW + 1 > 5) ? CW + 1 : 5;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PUSH  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]      state_q;
	logic [4:0]      cap_q;
	logic [CW-1:0]   cnt_q;
	logic            mk_q;
	logic [63:0]     mrev_q;
	logic [31:0]     mseq_q;
	logic [31:0]     nseq_q;
	logic [CW:0]     rem_q;
	logic            dmk_q;
	logic [19:0]     off_q;
	logic [31:0]     ictl_q;
	logic [2:0]      ikind_q;
	logic [63:0]     irev_q;
	logic [31:0]     igen_q;
	logic [15:0]     ilen_q;

	logic            m_valid_q;
	logic [207:0]    m_data_q;
	logic [2:0]      m_user_q;
	logic            m_last_q;

	ceq_pkg::cell_cmd_t cmd;
	ceq_pkg::entry_t    cell_q [CONTENT];
	ceq_pkg::entry_t    nxt_d  [CONTENT];
	logic [CONTENT:0]   sel;
	logic [CONTENT-1:0] load_en;
	ceq_pkg::entry_t    new_ent;
	logic [CW-1:0]      app_idx;

	logic            acc;
	logic            out_free;
	logic [CAPW-1:0] cap_eff;
	logic [CAPW-1:0] content;
	logic            full;
	logic            found;
	logic            in_mode;
	logic [2:0]      in_kind;
	logic [CW-1:0]   cnt_new;
	logic            mk_new;
	logic [CAPW-1:0] pend;

	logic            out_load;
	logic [207:0]    out_data;
	logic [2:0]      out_user;
	logic            out_last;

	assign s_tready = (state_q == S_IDLE);
	assign acc = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign in_mode = s_tuser;
	assign in_kind = s_tdata[34:32];
	assign found = sel[CONTENT];

	always_comb begin
		if (CAPW'(cap_q) < CAPW'(2)) begin
			cap_eff = CAPW'(2);
		end else if (CAPW'(cap_q) > CAPW'(MAX_SLOTS)) begin
			cap_eff = CAPW'(MAX_SLOTS);
		end else begin
			cap_eff = CAPW'(cap_q);
		end
		content = cap_eff - CAPW'(1);
		full = CAPW'(cnt_q) >= content;
	end

	always_comb begin
		cmd.op = ceq_pkg::OP_HOLD;
		cmd.kind = ikind_q;
		cmd.ctl = ictl_q;
		if (acc && !in_mode && (in_kind <= ceq_pkg::KIND_OVERFLOW)) begin
			cmd.op = ceq_pkg::OP_COAL;
			cmd.kind = in_kind;
			cmd.ctl = s_tdata[31:0];
		end else if (state_q == S_PUSH && out_free && ikind_q <= ceq_pkg::KIND_COMMAND &&
			full) begin
			cmd.op = ceq_pkg::OP_EVICT;
		end else if (state_q == S_DRAIN && out_free && rem_q != '0 && !dmk_q) begin
			cmd.op = ceq_pkg::OP_DRAIN;
		end
	end

	always_comb begin
		app_idx = found ? cnt_q - CW'(1) : cnt_q;
		new_ent.ctl = ictl_q;
		new_ent.kind = ikind_q;
		new_ent.rev = irev_q;
		new_ent.seq = full ? nseq_q + 32'd1 : nseq_q;
		new_ent.gen = igen_q;
		new_ent.len = ilen_q;
	end

	assign sel[0] = 1'b0;
	genvar gi;
	generate
		for (gi = 0; gi < CONTENT; gi++) begin : g_cell
			if (gi + 1 < CONTENT) begin : g_mid
				assign nxt_d[gi] = cell_q[gi+1];
			end else begin : g_end
				assign nxt_d[gi] = '0;
			end
			assign load_en[gi] = (state_q == S_PUSH) && out_free &&
				(ikind_q <= ceq_pkg::KIND_COMMAND) && !(full && !found) &&
				(app_idx == CW'(gi));
			ceq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occ      (CW'(gi) < cnt_q),
				.sel_in   (sel[gi]),
				.sel_out  (sel[gi+1]),
				.nxt      (nxt_d[gi]),
				.load_en  (load_en[gi]),
				.load_data(new_ent),
				.q        (cell_q[gi])
			);
		end
	endgenerate

	always_comb begin
		cnt_new = cnt_q;
		mk_new = mk_q;
		if (ikind_q <= ceq_pkg::KIND_COMMAND) begin
			if (full) begin
				mk_new = 1'b1;
			end else begin
				cnt_new = cnt_q + CW'(1);
			end
		end
		pend = CAPW'(cnt_new) + CAPW'(mk_new);
	end

	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		out_user = ceq_pkg::ST_PUSHED;
		out_last = 1'b1;
		case (state_q)
			S_PUSH: begin
				out_load = out_free;
				out_data[203:199] = pend[4:0];
				out_data[204] = mk_new;
				if (ikind_q > ceq_pkg::KIND_COMMAND) begin
					out_user = ceq_pkg::ST_UNKNOWN;
				end else if (full && !found) begin
					out_user = ceq_pkg::ST_REJECTED;
				end
			end
			S_DRAIN: begin
				out_load = out_free;
				out_last = (rem_q <= (CW+1)'(1));
				if (rem_q == '0) begin
					out_user = ceq_pkg::ST_EMPTY;
				end else begin
					out_user = ceq_pkg::ST_DRAINED;
					out_data[182:163] = off_q;
					if (dmk_q) begin
						out_data[34:32] = ceq_pkg::KIND_OVERFLOW;
						out_data[98:35] = mrev_q;
						out_data[130:99] = mseq_q;
					end else begin
						out_data[31:0] = cell_q[0].ctl;
						out_data[34:32] = cell_q[0].kind;
						out_data[98:35] = cell_q[0].rev;
						out_data[130:99] = cell_q[0].seq;
						out_data[162:131] = cell_q[0].gen;
						out_data[198:183] = cell_q[0].len;
					end
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= ceq_pkg::CAP_RESET;
			cnt_q <= '0;
			mk_q <= 1'b0;
			mrev_q <= '0;
			mseq_q <= '0;
			nseq_q <= '0;
			rem_q <= '0;
			dmk_q <= 1'b0;
			off_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (in_mode) begin
							state_q <= S_DRAIN;
							rem_q <= (CW+1)'(cnt_q) + (CW+1)'(mk_q);
							dmk_q <= mk_q;
							off_q <= '0;
							cnt_q <= '0;
							mk_q <= 1'b0;
						end else begin
							state_q <= S_PUSH;
							if (cmd.op == ceq_pkg::OP_COAL && found) begin
								cnt_q <= cnt_q - CW'(1);
							end
						end
					end
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (ikind_q <= ceq_pkg::KIND_COMMAND) begin
							if (full) begin
								mk_q <= 1'b1;
								mrev_q <= irev_q;
								mseq_q <= nseq_q;
								if (found) begin
									nseq_q <= nseq_q + 32'd2;
								end else begin
									nseq_q <= nseq_q + 32'd1;
								end
							end else begin
								cnt_q <= cnt_new;
								nseq_q <= nseq_q + 32'd1;
							end
						end
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						if (rem_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rem_q <= rem_q - (CW+1)'(1);
							if (rem_q == (CW+1)'(1)) begin
								state_q <= S_IDLE;
							end
							if (dmk_q) begin
								dmk_q <= 1'b0;
							end else begin
								off_q <= off_q + 20'(cell_q[0].len);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= out_data;
			m_user_q <= out_user;
			m_last_q <= out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ictl_q <= s_tdata[31:0];
			ikind_q <= s_tdata[34:32];
			irev_q <= s_tdata[98:35];
			igen_q <= s_tdata[130:99];
			ilen_q <= s_tdata[146:131];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;
	assign m_tlast = m_last_q;

	`CEQ_ASSERT(a_cnt_bound, (CAPW'(cnt_q) <= CAPW'(CONTENT)), "entry count beyond slots")
	`CEQ_ASSERT_IMP(a_drain_clear, state_q == S_DRAIN, (cnt_q == '0) && !mk_q, "drain with live queue")
	`CEQ_ASSERT_IMP(a_drain_enter, acc && in_mode, ##1 (state_q == S_DRAIN), "drain not started")
	`CEQ_ASSERT_IMP(a_evict_full, cmd.op == ceq_pkg::OP_EVICT, (state_q == S_PUSH) && full, "evict when not full")
endmodule

// ----- hdl/ceq_cell.sv -----
// One queue slot: key match, removal chain and shift from the next slot
module ceq_cell (
	input  logic               clk,
	input  ceq_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  logic               sel_in,
	output logic               sel_out,
	input  ceq_pkg::entry_t    nxt,
	input  logic               load_en,
	input  ceq_pkg::entry_t    load_data,
	output ceq_pkg::entry_t    q
);
	ceq_pkg::entry_t ent_q;
	logic hit;
	logic single;

	always_comb begin
		single = (cmd.kind == ceq_pkg::KIND_FOCUS) || (cmd.kind == ceq_pkg::KIND_CAPTURE) ||
			(cmd.kind == ceq_pkg::KIND_DIAG);
		case (cmd.op)
			ceq_pkg::OP_COAL:  hit = occ && (ent_q.kind == cmd.kind) &&
				(single || (ent_q.ctl == cmd.ctl));
			ceq_pkg::OP_EVICT: hit = occ && (ent_q.kind <= ceq_pkg::KIND_OVERFLOW);
			ceq_pkg::OP_DRAIN: hit = 1'b1;
			default:           hit = 1'b0;
		endcase
	end

	assign sel_out = sel_in | hit;
	assign q = ent_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			ent_q <= load_data;
		end else if (sel_out) begin
			ent_q <= nxt;
		end
	end
endmodule

// ----- bench/coalescing_event_queue_test.sv -----
// Self-checking testbench for the coalescing event queue: directed and random push/drain traffic
`timescale 1ns / 100ps
module coalescing_event_queue_test;
	localparam int CONTENT_MAX = 15;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [2:0]   status;
		logic         last;
		logic [207:0] data;
	} result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [4:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [207:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	coalescing_event_queue dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// predictor state
	ceq_pkg::entry_t q_slot [CONTENT_MAX];
	int unsigned q_count;
	logic        mk_present;
	logic [63:0] mk_rev;
	logic [31:0] mk_seq;
	logic [31:0] seq_next;
	logic [4:0]  cap_reg;

	result_t     expected_results [$];
	int          mismatches = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	longint      cycles = 0;

	function automatic logic [207:0] pack_out(ceq_pkg::entry_t e, logic [19:0] off,
			logic [4:0] pend, logic ovf);
		return {3'b0, ovf, pend, e.len, off, e.gen, e.seq, e.rev, e.kind, e.ctl};
	endfunction

	function automatic void queue_result(logic [2:0] st, logic lst, logic [207:0] d);
		result_t r;
		r.status = st;
		r.last = lst;
		r.data = d;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void remove_slot(int unsigned at);
		for (int unsigned i = at; i + 1 < q_count; i++)
			q_slot[i] = q_slot[i + 1];
		if (q_count > 0)
			q_count--;
	endfunction

	function automatic void predict_queue(logic mode, logic [31:0] ctl, logic [2:0] kind,
			logic [63:0] rev, logic [31:0] gen, logic [15:0] len);
		ceq_pkg::entry_t e;
		int unsigned content, total, k, n, cap;
		logic [19:0] off;
		logic        had, found;
		int          at;
		e = '0;
		if (mode) begin
			total = q_count + (mk_present ? 1 : 0);
			if (total == 0) begin
				queue_result(ceq_pkg::ST_EMPTY, 1'b1, '0);
				return;
			end
			had = mk_present;
			n = q_count;
			q_count = 0;
			mk_present = 1'b0;
			k = 0;
			off = '0;
			if (had) begin
				e.kind = ceq_pkg::KIND_OVERFLOW;
				e.rev = mk_rev;
				e.seq = mk_seq;
				queue_result(ceq_pkg::ST_DRAINED, k + 1 == total,
					pack_out(e, off, 5'd0, 1'b0));
				k++;
			end
			for (int unsigned i = 0; i < n; i++) begin
				queue_result(ceq_pkg::ST_DRAINED, k + 1 == total,
					pack_out(q_slot[i], off, 5'd0, 1'b0));
				off = off + 20'(q_slot[i].len);
				k++;
			end
			return;
		end
		if (kind > ceq_pkg::KIND_COMMAND) begin
			queue_result(ceq_pkg::ST_UNKNOWN, 1'b1, pack_out('0, '0, 5'(q_count + mk_present),
				mk_present));
			return;
		end
		cap = cap_reg;
		if (cap < 2) cap = 2;
		if (cap > 16) cap = 16;
		content = cap - 1;
		if (kind < ceq_pkg::KIND_COMMAND) begin
			for (int unsigned i = 0; i < q_count; i++) begin
				if (q_slot[i].kind == kind && (kind == ceq_pkg::KIND_FOCUS ||
						kind == ceq_pkg::KIND_CAPTURE || kind == ceq_pkg::KIND_DIAG ||
						q_slot[i].ctl == ctl)) begin
					remove_slot(i);
					break;
				end
			end
		end
		if (q_count >= content) begin
			found = 1'b0;
			at = 0;
			for (int unsigned i = 0; i < q_count; i++) begin
				if (q_slot[i].kind < ceq_pkg::KIND_COMMAND) begin
					found = 1'b1;
					at = i;
					break;
				end
			end
			mk_present = 1'b1;
			mk_rev = rev;
			mk_seq = seq_next;
			seq_next++;
			if (!found) begin
				queue_result(ceq_pkg::ST_REJECTED, 1'b1,
					pack_out('0, '0, 5'(q_count + 1), 1'b1));
				return;
			end
			remove_slot(at);
		end
		if (q_count < CONTENT_MAX) begin
			e.ctl = ctl;
			e.kind = kind;
			e.rev = rev;
			e.seq = seq_next;
			e.gen = gen;
			e.len = len;
			q_slot[q_count] = e;
			q_count++;
		end
		seq_next++;
		queue_result(ceq_pkg::ST_PUSHED, 1'b1,
			pack_out('0, '0, 5'(q_count + mk_present), mk_present));
	endfunction

	task automatic send_event(logic mode, logic [31:0] ctl, logic [2:0] kind, logic [63:0] rev,
			logic [31:0] gen, logic [15:0] len);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'b0, len, gen, rev, kind, ctl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_queue(mode, ctl, kind, rev, gen, len);
	endtask

	task automatic push_event(logic [2:0] kind, logic [31:0] ctl);
		send_event(1'b0, ctl, kind, {$urandom, $urandom}, $urandom, 16'($urandom));
	endtask

	task automatic drain_queue();
		send_event(1'b1, $urandom, 3'($urandom), {$urandom, $urandom}, $urandom, 16'($urandom));
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_capacity(logic [4:0] value);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = value;
	endtask

	// result checker
	always @(posedge clk) begin
		result_t r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction status=%0d data=%h", m_tuser, m_tdata);
				end else begin
					r = expected_results.pop_front();
					if (r.status !== m_tuser || r.last !== m_tlast || r.data !== m_tdata) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d last=%0d data=%h got st=%0d last=%0d data=%h",
								r.status, r.last, r.data, m_tuser, m_tlast, m_tdata);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL coalescing_event_queue");
			$finish;
		end
	end

	task automatic test_extremes();
		send_event(1'b1, '0, '0, '0, '0, '0);
		send_event(1'b0, '1, ceq_pkg::KIND_OVERFLOW, '1, '1, '1);
		send_event(1'b0, '0, ceq_pkg::KIND_FOCUS, '0, '0, '0);
		send_event(1'b0, 32'h1, 3'd1, '1, '1, '1);
		send_event(1'b0, 32'h1, 3'd6, '1, '1, '1);
		send_event(1'b0, 32'h1, 3'd7, '0, '0, '0);
		send_event(1'b1, '1, 3'd7, '1, '1, '1);
		send_event(1'b1, '0, '0, '0, '0, '0);
	endtask

	task automatic test_coalesce();
		push_event(ceq_pkg::KIND_FOCUS, 32'd1);
		push_event(ceq_pkg::KIND_FOCUS, 32'd2);
		push_event(3'd1, 32'd5);
		push_event(3'd1, 32'd6);
		push_event(3'd1, 32'd5);
		push_event(ceq_pkg::KIND_CAPTURE, 32'd0);
		push_event(ceq_pkg::KIND_DIAG, 32'd0);
		push_event(ceq_pkg::KIND_COMMAND, 32'd7);
		push_event(ceq_pkg::KIND_COMMAND, 32'd7);
		drain_queue();
	endtask

	task automatic test_overflow();
		set_capacity(5'd2);
		push_event(ceq_pkg::KIND_COMMAND, 32'd1);
		push_event(ceq_pkg::KIND_COMMAND, 32'd2);
		push_event(ceq_pkg::KIND_FOCUS, 32'd3);
		drain_queue();
		push_event(ceq_pkg::KIND_FOCUS, 32'd3);
		push_event(ceq_pkg::KIND_CAPTURE, 32'd3);
		drain_queue();
		set_capacity(5'd0);
		push_event(ceq_pkg::KIND_COMMAND, 32'd1);
		push_event(ceq_pkg::KIND_COMMAND, 32'd1);
		drain_queue();
	endtask

	task automatic random_phase(int items, logic [4:0] cap);
		logic [2:0] kind;
		set_capacity(cap);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 12)
				drain_queue();
			else begin
				kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) :
					3'($urandom_range(5));
				send_event(1'b0, ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3)),
					kind, {$urandom, $urandom}, $urandom, 16'($urandom));
			end
		end
		drain_queue();
	endtask

	task automatic test_random();
		send_idle = 24; recv_idle = 80;
		random_phase(120, 5'd16);
		random_phase(50, 5'd4);
		send_idle = 80; recv_idle = 24;
		random_phase(120, 5'd31);
		wait_quiet();
		random_phase(50, 5'd3);
		send_idle = 0; recv_idle = 0;
		random_phase(160, 5'd9);
		random_phase(20, 5'd16);
	endtask

	initial begin
		q_count = 0;
		mk_present = 1'b0;
		mk_rev = '0;
		mk_seq = '0;
		seq_next = '0;
		cap_reg = ceq_pkg::CAP_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_coalesce();
		test_overflow();
		test_random();
		wait_quiet();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS coalescing_event_queue");
		else
			$display("FAIL coalescing_event_queue");
		$finish;
	end
endmodule
